/* rtl/vrrf_pkg.sv */
package vrrf_pkg;

	// Store geometry
	localparam int QUEUE_BYTES = 1024;
	localparam int MAX_READ    = 64;
	localparam int HDR_BYTES   = 4;

	localparam int IDX_W   = $clog2(QUEUE_BYTES);
	localparam int FREE_W  = 11;
	localparam int LEN_W   = 10;
	localparam int RD_W    = $clog2(MAX_READ + 1);
	localparam int TOT_W   = LEN_W + 1;
	localparam int SUM_W   = ((IDX_W > TOT_W) ? IDX_W : TOT_W) + 1;
	localparam int NFREE_W = ((FREE_W > TOT_W) ? FREE_W : TOT_W) + 1;
	localparam int HCNT_W  = $clog2(HDR_BYTES);

	// Item kinds
	typedef enum logic [2:0] {
		KIND_BEGIN = 3'd0,
		KIND_DATA  = 3'd1,
		KIND_PEEK  = 3'd2,
		KIND_POP   = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_e;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_BUSY  = 2'd3
	} stat_e;

	// Controller states
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_HWR   = 7'b0000010,
		S_RH1   = 7'b0000100,
		S_RH2   = 7'b0001000,
		S_PRIME = 7'b0010000,
		S_DATA  = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [LEN_W-1:0] length;
		logic [7:0]       data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [7:0]        data_out;
		logic              has_data;
		logic              last;
		logic [FREE_W-1:0] free_bytes;
		logic              is_empty;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic  begin_push;
		logic  data_push;
		logic  clear;
		logic  hdr_wr;
		logic  rd_start;
		logic  rd_hdr;
		logic  hdr_done;
		logic  rd_data;
		logic  emit;
		stat_e stat;
		logic  has_data;
		logic  last;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic push_open;
		logic fits;
		logic empty;
		logic out_free;
		logic hdr_last;
		logic cnt_zero;
		logic cnt_last;
	} dp_stat_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		next_idx = (i == IDX_W'(QUEUE_BYTES - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

/* rtl/vrrf_ctrl.sv */
module vrrf_ctrl import vrrf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  req_t     req,
	input  dp_stat_t st,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   acc;

	assign req_ready = (state_q == S_IDLE) && st.out_free;
	assign acc       = req_valid && req_ready;

	// Sequencing and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.stat = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.kind) inside
						KIND_BEGIN: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (st.push_open) begin
								cmd.stat = STAT_BUSY;
							end else if (!st.fits) begin
								cmd.stat = STAT_FULL;
							end else begin
								cmd.begin_push = 1'b1;
								state_d = S_HWR;
							end
						end
						KIND_DATA: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							cmd.data_push = st.push_open;
						end
						KIND_PEEK, KIND_POP: begin
							if (st.push_open) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.stat = STAT_BUSY;
							end else if (st.empty) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.stat = STAT_EMPTY;
							end else begin
								cmd.rd_start = 1'b1;
								state_d = S_RH1;
							end
						end
						KIND_CLEAR: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (st.push_open) begin
								cmd.stat = STAT_BUSY;
							end else begin
								cmd.clear = 1'b1;
							end
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
						end
					endcase
				end
			end
			S_HWR: begin
				cmd.hdr_wr = 1'b1;
				if (st.hdr_last) begin
					state_d = S_IDLE;
				end
			end
			S_RH1: begin
				cmd.rd_hdr = 1'b1;
				state_d = S_RH2;
			end
			S_RH2: begin
				cmd.hdr_done = 1'b1;
				state_d = S_PRIME;
			end
			S_PRIME: begin
				if (st.cnt_zero) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.rd_data = 1'b1;
					state_d = S_DATA;
				end
			end
			S_DATA: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.has_data = 1'b1;
					cmd.last     = st.cnt_last;
					cmd.rd_data  = 1'b1;
					if (st.cnt_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("controller state not one-hot");
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == S_IDLE) || (state_q == S_HWR) || (state_q == S_RH1))
		else $error("bad state after accept");
	a_data_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) && cmd.emit && cmd.last |=> (state_q == S_IDLE))
		else $error("read did not end after last byte");

endmodule

/* rtl/vrrf_dp.sv */
module vrrf_dp import vrrf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_stat_t st,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rsp_t     rsp
);

	logic [7:0]        mem [QUEUE_BYTES];
	logic [7:0]        rdata_q;
	logic [IDX_W-1:0]  head_q, tail_q, ptr_q;
	logic [FREE_W-1:0] free_q, free_d;
	logic [LEN_W-1:0]  rem_q, len_q;
	logic              open_q;
	logic [HCNT_W-1:0] hcnt_q;
	logic [7:0]        lo_q;
	logic [RD_W-1:0]   want_q, cnt_q;
	logic              pop_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              wr_en, rd_en;
	logic [7:0]        wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [TOT_W-1:0]  req_tot, rec_tot;
	logic [LEN_W-1:0]  rec_len;
	logic [SUM_W-1:0]  head_sum;
	logic [IDX_W-1:0]  head_new;
	logic [NFREE_W-1:0] free_sum;
	logic [RD_W-1:0]   want_sat, n_rd;

	// Size arithmetic
	assign req_tot  = TOT_W'(HDR_BYTES) + TOT_W'(req.length);
	assign rec_len  = {rdata_q[LEN_W-9:0], lo_q};
	assign rec_tot  = TOT_W'(HDR_BYTES) + TOT_W'(rec_len);
	assign head_sum = SUM_W'(head_q) + SUM_W'(rec_tot);
	assign head_new = (head_sum >= SUM_W'(QUEUE_BYTES)) ?
		IDX_W'(head_sum - SUM_W'(QUEUE_BYTES)) : IDX_W'(head_sum);
	assign free_sum = NFREE_W'(free_q) + NFREE_W'(rec_tot);
	assign want_sat = (req.length > LEN_W'(MAX_READ)) ? RD_W'(MAX_READ) : RD_W'(req.length);
	assign n_rd     = (rec_len < LEN_W'(want_q)) ? RD_W'(rec_len) : want_q;

	always_comb begin
		free_d = free_q;
		if (cmd.begin_push) begin
			free_d = free_q - FREE_W'(req_tot);
		end else if (cmd.clear) begin
			free_d = FREE_W'(QUEUE_BYTES);
		end else if (cmd.hdr_done && pop_q) begin
			free_d = (free_sum > NFREE_W'(QUEUE_BYTES)) ?
				FREE_W'(QUEUE_BYTES) : FREE_W'(free_sum);
		end
	end

	// Store write: header bytes and payload bytes at the tail
	assign wr_en = cmd.begin_push || cmd.hdr_wr || cmd.data_push;
	always_comb begin
		wr_data = 8'h00;
		if (cmd.begin_push) begin
			wr_data = req.length[7:0];
		end else if (cmd.data_push) begin
			wr_data = req.data_byte;
		end else if (hcnt_q == HCNT_W'(1)) begin
			wr_data = 8'(len_q >> 8);
		end
	end

	assign rd_en   = cmd.rd_start || cmd.rd_hdr || cmd.rd_data;
	assign rd_addr = cmd.rd_start ? head_q : ptr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Queue pointers and push state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			free_q <= FREE_W'(QUEUE_BYTES);
			rem_q  <= '0;
			open_q <= 1'b0;
			hcnt_q <= '0;
		end else begin
			free_q <= free_d;
			if (cmd.clear) begin
				tail_q <= head_q;
			end else if (wr_en) begin
				tail_q <= next_idx(tail_q);
			end
			if (cmd.hdr_done && pop_q) begin
				head_q <= head_new;
			end
			if (cmd.begin_push) begin
				rem_q  <= req.length;
				open_q <= (req.length != '0);
				hcnt_q <= HCNT_W'(1);
			end else if (cmd.data_push) begin
				rem_q <= rem_q - 1'b1;
				if (rem_q == LEN_W'(1)) begin
					open_q <= 1'b0;
				end
			end
			if (cmd.hdr_wr) begin
				hcnt_q <= hcnt_q + 1'b1;
			end
		end
	end

	// Read-side registers
	always_ff @(posedge clk) begin
		if (cmd.begin_push) begin
			len_q <= req.length;
		end
		if (cmd.rd_start) begin
			want_q <= want_sat;
			pop_q  <= (req.kind == KIND_POP);
		end
		if (cmd.rd_hdr) begin
			lo_q <= rdata_q;
		end
		if (cmd.hdr_done) begin
			cnt_q <= n_rd;
		end else if (cmd.emit && cmd.has_data) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.rd_start) begin
			ptr_q <= next_idx(head_q);
		end else if (cmd.hdr_done) begin
			ptr_q <= next_idx(next_idx(ptr_q));
		end else if (cmd.rd_hdr || cmd.rd_data) begin
			ptr_q <= next_idx(ptr_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status     <= cmd.stat;
			out_q.data_out   <= cmd.has_data ? rdata_q : 8'h00;
			out_q.has_data   <= cmd.has_data;
			out_q.last       <= cmd.last;
			out_q.free_bytes <= free_d;
			out_q.is_empty   <= (free_d == FREE_W'(QUEUE_BYTES));
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Status to controller
	assign st.push_open = open_q;
	assign st.fits      = (FREE_W'(req_tot) <= free_q);
	assign st.empty     = (free_q == FREE_W'(QUEUE_BYTES));
	assign st.out_free  = !out_valid_q || rsp_ready;
	assign st.hdr_last  = (hcnt_q == HCNT_W'(HDR_BYTES - 1));
	assign st.cnt_zero  = (cnt_q == '0);
	assign st.cnt_last  = (cnt_q == RD_W'(1));

	// Checks
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(QUEUE_BYTES)) else $error("free count above store size");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free) else $error("result register overwritten");
	a_open_rem: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == (rem_q != '0)) else $error("push state and remaining count disagree");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < IDX_W'(QUEUE_BYTES - 1) || head_q == IDX_W'(QUEUE_BYTES - 1)) &&
		(tail_q < IDX_W'(QUEUE_BYTES - 1) || tail_q == IDX_W'(QUEUE_BYTES - 1)))
		else $error("index outside store");

endmodule

/* rtl/variable_record_ring_fifo_core.sv */
// Queue of variable-length byte records in a 1024-byte circular store; each record is a
// 4-byte little-endian length header followed by its payload, and both may wrap. Every item
// gives one result, except a peek or pop that returns n > 0 bytes, which gives n results
// with last on the final one. An item is taken only while the controller is idle and the
// result register is empty or being drained. A begin push writes its header with one store
// write per header byte on the single write port; a peek or pop reads the header and primes
// the store read port, then delivers one payload byte per cycle while the consumer keeps
// up. The store needs no clearing pass after reset.
module variable_record_ring_fifo_core import vrrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t st;

	vrrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.st        (st),
		.cmd       (cmd)
	);

	vrrf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* tb/record_fifo_checker.sv */
`timescale 1ns / 100ps

module record_fifo_checker import vrrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	// Mirror of the byte ring, its pointers and the open push
	logic [7:0]       ring [QUEUE_BYTES];
	logic [IDX_W-1:0] rd_ptr;
	logic [IDX_W-1:0] wr_ptr;
	int unsigned      room;
	logic [LEN_W-1:0] bytes_left;
	logic             push_busy;

	// Results owed by the block, oldest first
	rsp_t owed [$];
	int   mismatches = 0;
	int   owed_n     = 0;

	assign fail_count = mismatches;
	assign pending    = owed_n;

	task report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// Queue one result, tagged with the free count after the item
	function automatic void owe(input stat_e st, input logic [7:0] d, input logic has,
		input logic fin);
		rsp_t r;
		r.status     = st;
		r.data_out   = d;
		r.has_data   = has;
		r.last       = fin;
		r.free_bytes = FREE_W'(room);
		r.is_empty   = (room == QUEUE_BYTES);
		owed.push_back(r);
	endfunction

	// Peek or pop of the oldest record; a pop frees header and whole payload
	function automatic void predict_read(input int unsigned want, input bit drop);
		logic [IDX_W-1:0] p;
		int unsigned      len;
		int unsigned      n;
		int unsigned      total;
		logic [7:0]       got [MAX_READ];
		p   = rd_ptr;
		len = 0;
		// ring size is a power of two, so pointers wrap by themselves
		for (int i = 0; i < HDR_BYTES; i++) begin
			len = len | (int'(ring[p]) << (8 * i));
			p   = p + 1'b1;
		end
		n = (len < want) ? len : want;
		for (int i = 0; i < n; i++) begin
			got[i] = ring[p];
			p      = p + 1'b1;
		end
		if (drop) begin
			total  = HDR_BYTES + len;
			rd_ptr = IDX_W'(int'(rd_ptr) + total);
			room   = (room + total > QUEUE_BYTES) ? QUEUE_BYTES : room + total;
		end
		if (n == 0)
			owe(STAT_OK, 8'h00, 1'b0, 1'b1);
		else
			for (int i = 0; i < n; i++)
				owe(STAT_OK, got[i], 1'b1, i == n - 1);
	endfunction

	// Expected results of one accepted item
	function automatic void predict_item(input req_t it);
		int unsigned want;
		case (it.kind) inside
			KIND_BEGIN: begin
				if (push_busy)
					owe(STAT_BUSY, 8'h00, 1'b0, 1'b1);
				else if (room < HDR_BYTES + it.length)
					owe(STAT_FULL, 8'h00, 1'b0, 1'b1);
				else begin
					room = room - HDR_BYTES - it.length;
					// little-endian length header
					for (int i = 0; i < HDR_BYTES; i++) begin
						ring[wr_ptr] = 8'(32'(it.length) >> (8 * i));
						wr_ptr       = wr_ptr + 1'b1;
					end
					bytes_left = it.length;
					push_busy  = (it.length != 0);
					owe(STAT_OK, 8'h00, 1'b0, 1'b1);
				end
			end
			KIND_DATA: begin
				// a stray byte with no open push is dropped
				if (push_busy) begin
					ring[wr_ptr] = it.data_byte;
					wr_ptr       = wr_ptr + 1'b1;
					bytes_left   = bytes_left - 1'b1;
					if (bytes_left == 0)
						push_busy = 1'b0;
				end
				owe(STAT_OK, 8'h00, 1'b0, 1'b1);
			end
			KIND_PEEK, KIND_POP: begin
				if (push_busy)
					owe(STAT_BUSY, 8'h00, 1'b0, 1'b1);
				else if (room == QUEUE_BYTES)
					owe(STAT_EMPTY, 8'h00, 1'b0, 1'b1);
				else begin
					want = (it.length > MAX_READ) ? MAX_READ : it.length;
					predict_read(want, it.kind == KIND_POP);
				end
			end
			KIND_CLEAR: begin
				if (push_busy)
					owe(STAT_BUSY, 8'h00, 1'b0, 1'b1);
				else begin
					wr_ptr = rd_ptr;
					room   = QUEUE_BYTES;
					owe(STAT_OK, 8'h00, 1'b0, 1'b1);
				end
			end
			default: owe(STAT_OK, 8'h00, 1'b0, 1'b1);
		endcase
	endfunction

	// Watch both channels: predict on input, compare on output
	always @(posedge clk) begin
		rsp_t exp_r;
		if (!arst_n) begin
			rd_ptr     = '0;
			wr_ptr     = '0;
			room       = QUEUE_BYTES;
			bytes_left = '0;
			push_busy  = 1'b0;
			owed.delete();
			owed_n <= 0;
		end else begin
			if (req_valid && req_ready)
				predict_item(req);
			if (rsp_valid && rsp_ready) begin
				if (owed.size() == 0)
					report_mismatch($sformatf("result %h with none expected", rsp));
				else begin
					exp_r = owed.pop_front();
					check_field("status", rsp.status, exp_r.status);
					check_field("data_out", rsp.data_out, exp_r.data_out);
					check_field("has_data", rsp.has_data, exp_r.has_data);
					check_field("last", rsp.last, exp_r.last);
					check_field("free_bytes", rsp.free_bytes, exp_r.free_bytes);
					check_field("is_empty", rsp.is_empty, exp_r.is_empty);
				end
			end
			owed_n <= owed.size();
		end
	end

endmodule

/* tb/tb_variable_record_ring_fifo_core.sv */
`timescale 1ns / 100ps

module tb_variable_record_ring_fifo_core;
	import vrrf_pkg::*;

	localparam int         CYCLE_LIMIT = 2000000;
	localparam int         LONG_HOLD   = 200;
	localparam int         RAND_ITEMS  = 240;
	localparam int         CALM_ITEMS  = 70;
	localparam int         LEN_MAX     = 1020;
	localparam int         BIG_LEN     = 180;
	localparam logic [2:0] KIND_TOP    = 3'd7;   // highest code the kind field carries

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   fail_count;
	int   pending;

	// Lengths of the records the sender believes are stored, to pick pushes that fit
	int unsigned rec_lens [$];
	int unsigned room_left = QUEUE_BYTES;
	int          sent      = 0;
	bit          calm      = 1'b0;
	int          hold_reqs = 0;
	int          cycles    = 0;

	variable_record_ring_fifo_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	record_fifo_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random stall bursts, one long hold on request
	initial begin : sink
		int holds_done;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			if (hold_reqs != holds_done) begin
				holds_done++;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Offer one item, maybe after an idle burst, and return once it is taken
	task automatic send(input logic [2:0] k, input int unsigned len, input logic [7:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{kind: k, length: LEN_W'(len), data_byte: b};
		do @(posedge clk); while (!req_ready);
		sent++;
	endtask

	// Item sent while a push is open: all of these are refused as busy or ignored
	task automatic send_noise();
		logic [2:0] k;
		case ($urandom_range(0, 4))
			0:       k = KIND_BEGIN;
			1:       k = KIND_PEEK;
			2:       k = KIND_POP;
			3:       k = KIND_CLEAR;
			default: k = 3'($urandom_range(KIND_CLEAR + 1, KIND_TOP));
		endcase
		send(k, $urandom_range(0, LEN_MAX), 8'($urandom));
	endtask

	// Begin a record and fill it, with busy noise mixed in at the given percent
	task automatic push_record(input int unsigned len, input int noise_pct);
		bit fits;
		fits = (room_left >= HDR_BYTES + len);
		send(KIND_BEGIN, len, 8'($urandom));
		if (fits) begin
			room_left -= HDR_BYTES + len;
			rec_lens.push_back(len);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < noise_pct)
					send_noise();
				send(KIND_DATA, $urandom_range(0, LEN_MAX), 8'($urandom));
			end
		end
	endtask

	task automatic read_rec(input logic [2:0] k, input int unsigned want);
		send(k, want, 8'($urandom));
		if (k == KIND_POP && rec_lens.size() != 0)
			room_left += HDR_BYTES + rec_lens.pop_front();
	endtask

	task automatic clear_all();
		send(KIND_CLEAR, $urandom_range(0, LEN_MAX), 8'($urandom));
		rec_lens.delete();
		room_left = QUEUE_BYTES;
	endtask

	// Stop offering until every owed result has come out
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		int          rand_start;
		int          pick;
		bit          paused;
		int unsigned n;
		paused = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, stray data byte, unused kinds
		read_rec(KIND_PEEK, 5);
		read_rec(KIND_POP, 0);
		clear_all();
		send(KIND_DATA, 0, 8'h3C);
		send(3'(KIND_CLEAR + 1), 0, 8'h00);
		send(KIND_TOP, LEN_MAX, 8'hFF);

		// Zero-length record: reads give one empty result, pop frees the header
		push_record(0, 0);
		read_rec(KIND_PEEK, 9);
		read_rec(KIND_POP, 0);

		// Short record with every busy case while it is open
		send(KIND_BEGIN, 3, 8'h5A);
		room_left -= HDR_BYTES + 3;
		rec_lens.push_back(3);
		send(KIND_DATA, 0, 8'h00);
		send(KIND_PEEK, 1, 8'h00);
		send(KIND_BEGIN, 1, 8'h00);
		send(KIND_CLEAR, 0, 8'h00);
		send(KIND_POP, LEN_MAX, 8'h00);
		send(KIND_DATA, LEN_MAX, 8'hFF);
		send(KIND_DATA, 0, 8'hA5);

		// Refused push, saturated and truncated reads
		push_record(LEN_MAX, 0);
		read_rec(KIND_PEEK, LEN_MAX);
		read_rec(KIND_PEEK, 0);
		read_rec(KIND_POP, 2);
		read_rec(KIND_PEEK, 3);

		// Clear with a record stored
		push_record(2, 0);
		clear_all();
		read_rec(KIND_POP, 3);
		wait_drained();

		// Large record pushed and read back; long result stall meanwhile
		hold_reqs++;
		push_record(BIG_LEN, 0);
		push_record(0, 0);
		read_rec(KIND_PEEK, MAX_READ);
		read_rec(KIND_POP, LEN_MAX);

		// Random mix, mostly well-formed pushes with reads and some noise
		rand_start = sent;
		while (sent - rand_start < RAND_ITEMS) begin
			calm = (sent - rand_start > RAND_ITEMS - CALM_ITEMS);
			if (!paused && sent - rand_start > RAND_ITEMS / 2) begin
				paused = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(0, 16);
				push_record(n, 8);
			end else if (pick < 88) begin
				n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, LEN_MAX)
					: $urandom_range(0, 70);
				read_rec((pick < 60) ? KIND_PEEK : KIND_POP, n);
			end else if (pick < 91)
				clear_all();
			else if (pick < 96)
				send(KIND_DATA, $urandom_range(0, LEN_MAX), 8'($urandom));
			else
				send(3'($urandom_range(KIND_CLEAR + 1, KIND_TOP)), $urandom_range(0, LEN_MAX),
					8'($urandom));
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
